>>> hw/rtl/sil_pkg.sv
`default_nettype none

package sil_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = $clog2(MAX_KNOTS);
    localparam int STEPS     = IDX_W;
    localparam int CNT_W     = 7;
    localparam int KW        = 32;
    localparam int FRAC      = 16;
    localparam int QW        = KW + 1;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    localparam logic [KW-1:0] SAT_MAX = {1'b0, {(KW-1){1'b1}}};
    localparam logic [KW-1:0] SAT_MIN = {1'b1, {(KW-1){1'b0}}};

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] slot;
        logic [KW-1:0]    pos;
        logic             outside;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [KW-1:0]    lo_val;
        logic [KW-1:0]    hi_val;
    } srch_t;

    typedef struct packed {
        srch_t            s;
        logic [IDX_W-1:0] mid;
        logic [KW-1:0]    mval;
    } bis_t;

    typedef struct packed {
        logic             func;
        logic             outside;
        logic [IDX_W-1:0] lo;
        logic             zero_h;
        logic             num_pos;
        logic             num_neg;
        logic             neg;
        logic             ovf;
        logic [QW-1:0]    rem;
        logic [QW-1:0]    dvd;
        logic [QW-1:0]    q;
        logic [QW-1:0]    dvs;
    } dv_t;

    function automatic logic [IDX_W-1:0] bis_mid(srch_t s);
        logic [IDX_W:0] sum;
        sum = {1'b0, s.lo} + {1'b0, s.hi};
        return sum[IDX_W:1];
    endfunction

    function automatic srch_t bis_resolve(bis_t b);
        srch_t s;
        s = b.s;
        if ((b.s.hi - b.s.lo) > IDX_W'(1))
        begin
            if ($signed(b.mval) > $signed(b.s.pos))
            begin
                s.hi     = b.mid;
                s.hi_val = b.mval;
            end
            else
            begin
                s.lo     = b.mid;
                s.lo_val = b.mval;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sil_bisect_stage.sv
`default_nettype none

module sil_bisect_stage
    import sil_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   adv,
    input  wire   in_valid,
    input  srch_t in_s,
    output logic  out_valid,
    output bis_t  out_b
);

    logic [KW-1:0]    mem [MAX_KNOTS];
    logic             valid_reg;
    bis_t             b_reg;
    logic [IDX_W-1:0] mid;

    assign mid = bis_mid(in_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // a load writes this copy as it passes, so later requests see it here
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_valid && in_s.func == FUNC_LOAD)
                mem[in_s.slot] <= in_s.pos;
            b_reg.s    <= in_s;
            b_reg.mid  <= mid;
            b_reg.mval <= mem[mid];
        end
    end

    assign out_valid = valid_reg;
    assign out_b     = b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sil_div_stage.sv
`default_nettype none

module sil_div_stage
    import sil_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  adv,
    input  wire  in_valid,
    input  dv_t  in_d,
    output logic out_valid,
    output dv_t  out_d
);

    logic          valid_reg;
    dv_t           d_reg;
    dv_t           d_next;
    logic [QW:0]   trial;

    always_comb
    begin
        d_next     = in_d;
        trial      = {in_d.rem, in_d.dvd[QW-1]};
        d_next.dvd = {in_d.dvd[QW-2:0], 1'b0};
        if (trial >= {1'b0, in_d.dvs})
        begin
            trial    = trial - {1'b0, in_d.dvs};
            d_next.q = {in_d.q[QW-2:0], 1'b1};
        end
        else
        begin
            d_next.q = {in_d.q[QW-2:0], 1'b0};
        end
        d_next.rem = trial[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

`default_nettype wire

>>> hw/rtl/spline_interval_locate_unit.sv
`default_nettype none
// Knot interval locator.
// Slave stream: tuser = func (0 query, 1 load knot); tdata = knot_slot [5:0],
// position [37:6] (signed Q16.16). Loads write one knot table entry and give
// no result. Each query gives one master-stream result: tuser = inside_res,
// tdata = lower_knot [5:0], shift_fraction [37:6] (signed Q16.16, saturated).
// cfg_we / cfg_wdata write knot_count; write it only while the block is idle.
// A request is loaded into the input stage with the first table copy at the
// accepting edge, then passes six bisection stages each with its own table
// copy read at the midpoint, one setup stage, 33 one-bit divider stages and
// the output register, where its result becomes valid. One item enters every
// cycle while the pipeline is not stalled.
// Reset clears all valid bits and sets knot_count to 2; the knot table is
// not cleared and must be loaded before it is queried.
// When the receiver holds tready low with a result waiting, the whole
// pipeline and s_axis_tready stop until the result is taken; nothing is lost.

module spline_interval_locate_unit
    import sil_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  [39:0]       s_axis_tdata,  // knot_slot[5:0], position[37:6], zeros
    input  wire               s_axis_tuser,  // func
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // lower_knot[5:0], shift_fraction[37:6], zeros
    output logic              m_axis_tuser,  // inside_res
    input  wire               cfg_we,
    input  wire  [CNT_W-1:0]  cfg_wdata
);

    logic             adv;
    logic [CNT_W-1:0] knot_count_reg;
    logic [IDX_W-1:0] last_idx;

    logic [KW-1:0]    mem0 [MAX_KNOTS];
    logic             p0_valid_reg;
    logic             p0_func_reg;
    logic [IDX_W-1:0] p0_slot_reg;
    logic [KW-1:0]    p0_pos_reg;
    logic [IDX_W-1:0] p0_last_reg;
    logic [KW-1:0]    p0_first_val_reg;
    logic [KW-1:0]    p0_last_val_reg;

    srch_t            st_in  [STEPS];
    bis_t             st_out [STEPS];
    logic             st_v   [STEPS];

    srch_t            fin;
    logic [QW-1:0]    num;
    logic [QW-1:0]    h;
    logic [QW-1:0]    anum;
    logic [QW-1:0]    ah;
    dv_t              prep_next;
    dv_t              prep_reg;
    logic             prep_valid_reg;

    dv_t              dv_d [QW+1];
    logic             dv_v [QW+1];

    dv_t              last_d;
    logic             res_inside;
    logic [IDX_W-1:0] res_lo;
    logic [KW-1:0]    res_frac;

    logic             out_valid_reg;
    logic             out_user_reg;
    logic [39:0]      out_data_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            knot_count_reg <= CNT_W'(2);
        else if (cfg_we)
            knot_count_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (knot_count_reg < CNT_W'(2))
            last_idx = IDX_W'(1);
        else if (knot_count_reg > CNT_W'(MAX_KNOTS))
            last_idx = IDX_W'(MAX_KNOTS - 1);
        else
            last_idx = IDX_W'(knot_count_reg - CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else if (adv)
            p0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s_axis_tvalid && s_axis_tuser == FUNC_LOAD)
                mem0[s_axis_tdata[IDX_W-1:0]] <= s_axis_tdata[IDX_W+KW-1:IDX_W];
            p0_func_reg      <= s_axis_tuser;
            p0_slot_reg      <= s_axis_tdata[IDX_W-1:0];
            p0_pos_reg       <= s_axis_tdata[IDX_W+KW-1:IDX_W];
            p0_last_reg      <= last_idx;
            p0_first_val_reg <= mem0[0];
            p0_last_val_reg  <= mem0[last_idx];
        end
    end

    always_comb
    begin
        st_in[0].func    = p0_func_reg;
        st_in[0].slot    = p0_slot_reg;
        st_in[0].pos     = p0_pos_reg;
        st_in[0].outside = $signed(p0_pos_reg) > $signed(p0_last_val_reg);
        st_in[0].lo      = '0;
        st_in[0].hi      = p0_last_reg;
        st_in[0].lo_val  = p0_first_val_reg;
        st_in[0].hi_val  = p0_last_val_reg;
    end

    for (genvar g = 0; g < STEPS; g++)
    begin : g_bis
        if (g > 0)
        begin : g_link
            assign st_in[g] = bis_resolve(st_out[g-1]);
        end
        sil_bisect_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  ((g == 0) ? p0_valid_reg : st_v[(g == 0) ? 0 : g-1]),
            .in_s      (st_in[g]),
            .out_valid (st_v[g]),
            .out_b     (st_out[g])
        );
    end

    assign fin  = bis_resolve(st_out[STEPS-1]);
    assign num  = {fin.pos[KW-1], fin.pos} - {fin.lo_val[KW-1], fin.lo_val};
    assign h    = {fin.hi_val[KW-1], fin.hi_val} - {fin.lo_val[KW-1], fin.lo_val};
    assign anum = num[QW-1] ? -num : num;
    assign ah   = h[QW-1] ? -h : h;

    always_comb
    begin
        prep_next.func    = fin.func;
        prep_next.outside = fin.outside;
        prep_next.lo      = fin.lo;
        prep_next.zero_h  = (h == '0);
        prep_next.num_pos = !num[QW-1] && (num != '0);
        prep_next.num_neg = num[QW-1];
        prep_next.neg     = num[QW-1] ^ h[QW-1];
        prep_next.rem     = {{(QW-FRAC){1'b0}}, anum[QW-1:QW-FRAC]};
        prep_next.dvd     = {anum[QW-FRAC-1:0], {FRAC{1'b0}}};
        prep_next.q       = '0;
        prep_next.dvs     = ah;
        prep_next.ovf     = ({{(QW-FRAC){1'b0}}, anum[QW-1:QW-FRAC]} >= ah);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (adv)
            prep_valid_reg <= st_v[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prep_reg <= prep_next;
    end

    assign dv_d[0] = prep_reg;
    assign dv_v[0] = prep_valid_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        sil_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_v[k]),
            .in_d      (dv_d[k]),
            .out_valid (dv_v[k+1]),
            .out_d     (dv_d[k+1])
        );
    end

    assign last_d = dv_d[QW];

    always_comb
    begin
        res_inside = 1'b1;
        res_lo     = last_d.lo;
        res_frac   = '0;
        priority if (last_d.outside)
        begin
            res_inside = 1'b0;
            res_lo     = '0;
            res_frac   = '0;
        end
        else if (last_d.zero_h)
        begin
            if (last_d.num_pos)
                res_frac = SAT_MAX;
            else if (last_d.num_neg)
                res_frac = SAT_MIN;
            else
                res_frac = '0;
        end
        else if (last_d.ovf)
            res_frac = last_d.neg ? SAT_MIN : SAT_MAX;
        else if (last_d.neg)
            res_frac = (last_d.q > {1'b0, SAT_MIN}) ? SAT_MIN : -last_d.q[KW-1:0];
        else
            res_frac = (last_d.q > {1'b0, SAT_MAX}) ? SAT_MAX : last_d.q[KW-1:0];
    end

    // drop loads at the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v[QW] && last_d.func == FUNC_QUERY;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_user_reg <= res_inside;
            out_data_reg <= {{(40-KW-IDX_W){1'b0}}, res_frac, res_lo};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
